// ===== design/disa_pkg.sv =====
package disa_pkg;

    localparam int NUM_SLOTS         = 16;
    localparam int MAX_MODULES       = 32;
    localparam int PACKETS_PER_FRAME = 128;

    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int MOD_W     = $clog2(MAX_MODULES);
    localparam int CNT_W     = $clog2(MAX_MODULES + 1);
    localparam int ADDR_W    = SLOT_W + MOD_W;
    localparam int MEM_DEPTH = NUM_SLOTS * MAX_MODULES;
    localparam int PID_W     = 64;
    localparam int REC_W     = 32;
    localparam int PKT_W     = 8;
    localparam int MODE_W    = 3;
    localparam int CFG_W     = 6;

    localparam logic [CNT_W-1:0] NMOD_MAX   = CNT_W'(MAX_MODULES);
    localparam logic [PKT_W-1:0] PKT_FULL   = PKT_W'(PACKETS_PER_FRAME);

    localparam logic [MODE_W-1:0] MODE_CLAIM  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ARRIVE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FREE   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ASM    = 3'd4;

    typedef struct packed {
        logic [PID_W-1:0] pulse;
        logic [PID_W-1:0] frame;
        logic [REC_W-1:0] record;
        logic [PKT_W-1:0] packets;
    } t_meta;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [PID_W-1:0]  pulse_no;
        logic [MOD_W-1:0]  module_index;
        logic [PID_W-1:0]  frame_pulse;
        logic [PID_W-1:0]  frame_number;
        logic [REC_W-1:0]  acq_record;
        logic [PKT_W-1:0]  packets_received;
    } t_in_item;

    typedef struct packed {
        logic             answer_flag;
        logic             image_good;
        logic [PID_W-1:0] image_pulse;
        logic [PID_W-1:0] image_frame;
        logic [REC_W-1:0] image_record;
    } t_out_item;

    typedef struct packed {
        logic             accept;
        logic             rd_en;
        logic [MOD_W-1:0] rd_idx;
        logic             emit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic             out_free;
        logic [CNT_W-1:0] module_count;
    } t_dp_stat;

endpackage

// ===== design/disa_in_if.sv =====
interface disa_in_if
    import disa_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [PID_W-1:0]  pulse_no;
    logic [MOD_W-1:0]  module_index;
    logic [PID_W-1:0]  frame_pulse;
    logic [PID_W-1:0]  frame_number;
    logic [REC_W-1:0]  acq_record;
    logic [PKT_W-1:0]  packets_received;

    modport source (
        output valid, mode, pulse_no, module_index, frame_pulse, frame_number,
               acq_record, packets_received,
        input  ready
    );
    modport sink (
        input  valid, mode, pulse_no, module_index, frame_pulse, frame_number,
               acq_record, packets_received,
        output ready
    );
endinterface

// ===== design/disa_out_if.sv =====
interface disa_out_if
    import disa_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             answer_flag;
    logic             image_good;
    logic [PID_W-1:0] image_pulse;
    logic [PID_W-1:0] image_frame;
    logic [REC_W-1:0] image_record;

    modport source (
        output valid, answer_flag, image_good, image_pulse, image_frame, image_record,
        input  ready
    );
    modport sink (
        input  valid, answer_flag, image_good, image_pulse, image_frame, image_record,
        output ready
    );
endinterface

// ===== design/disa_ctrl.sv =====
module disa_ctrl
    import disa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [MODE_W-1:0] i_in_mode,
    output logic              o_in_ready,
    input  t_dp_stat          i_stat,
    output t_ctrl_cmd         o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic             accept;
    logic             walk_issue;

    assign o_in_ready = (r_state == ST_IDLE) && i_stat.out_free;
    assign accept     = i_in_valid && o_in_ready;
    assign walk_issue = (r_state == ST_WALK) && (r_idx != i_stat.module_count);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_in_mode == MODE_ASM)) begin
                    n_state = ST_WALK;
                    n_idx   = '0;
                end
            end
            ST_WALK: begin
                // last fetched entry is checked in the cycle the walk ends
                if (walk_issue) begin
                    n_idx = r_idx + CNT_W'(1);
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        o_cmd.accept = accept;
        o_cmd.rd_en  = walk_issue;
        o_cmd.rd_idx = r_idx[MOD_W-1:0];
        o_cmd.emit   = (r_state == ST_EMIT) && i_stat.out_free;
    end

endmodule

// ===== design/disa_dp.sv =====
module disa_dp
    import disa_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CFG_W-1:0] i_cfg_wr_data,
    input  t_in_item         i_item,
    input  t_ctrl_cmd        i_cmd,
    output t_dp_stat         o_stat,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out
);

    logic [CNT_W-1:0]  r_module_count;
    logic [PID_W-1:0]  r_owner   [NUM_SLOTS];
    logic              r_claimed [NUM_SLOTS];
    logic [CNT_W-1:0]  r_pending [NUM_SLOTS];
    t_meta             r_mem     [MEM_DEPTH];
    t_meta             r_rd_data;
    logic              r_chk_vld;
    logic [SLOT_W-1:0] r_slot;

    logic              r_good, n_good;
    logic              r_seen, n_seen;
    logic [PID_W-1:0]  r_ipulse, n_ipulse;
    logic [PID_W-1:0]  r_iframe, n_iframe;
    logic [REC_W-1:0]  r_irec, n_irec;

    logic              r_out_valid;
    t_out_item         r_out, n_out;

    logic [SLOT_W-1:0] slot;
    logic              arrive_ok;
    logic              claim_flag;
    logic              query_flag;
    logic              is_asm;
    logic              load_simple;
    logic [CNT_W-1:0]  cfg_val;

    assign slot       = i_item.pulse_no[SLOT_W-1:0];
    assign arrive_ok  = ({1'b0, i_item.module_index} < r_module_count);
    assign claim_flag = !r_claimed[slot]
                        || ((r_pending[slot] != '0) && (r_owner[slot] == i_item.pulse_no));
    assign query_flag = (r_pending[slot] == '0);
    assign is_asm     = (i_item.mode == MODE_ASM);
    assign load_simple = i_cmd.accept && !is_asm;

    always_comb begin
        if (CNT_W'(i_cfg_wr_data) > NMOD_MAX) begin
            cfg_val = NMOD_MAX;
        end else begin
            cfg_val = CNT_W'(i_cfg_wr_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_module_count <= NMOD_MAX;
        end else if (i_cfg_wr_en) begin
            r_module_count <= cfg_val;
        end
    end

    // slot bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
                r_owner[s]   <= '0;
                r_claimed[s] <= 1'b0;
                r_pending[s] <= NMOD_MAX;
            end
        end else if (i_cmd.accept) begin
            case (i_item.mode)
                MODE_CLAIM: begin
                    if (!r_claimed[slot]) begin
                        r_claimed[slot] <= 1'b1;
                        r_owner[slot]   <= i_item.pulse_no;
                    end
                end
                MODE_ARRIVE: begin
                    if (arrive_ok && (r_pending[slot] != '0)) begin
                        r_pending[slot] <= r_pending[slot] - CNT_W'(1);
                    end
                end
                MODE_FREE: begin
                    r_pending[slot] <= r_module_count;
                    r_claimed[slot] <= 1'b0;
                    r_owner[slot]   <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // metadata memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (i_item.mode == MODE_ARRIVE) && arrive_ok) begin
            r_mem[{slot, i_item.module_index}] <= '{
                pulse:   i_item.frame_pulse,
                frame:   i_item.frame_number,
                record:  i_item.acq_record,
                packets: i_item.packets_received
            };
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[{r_slot, i_cmd.rd_idx}];
        end
        if (i_cmd.accept) begin
            r_slot <= slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk_vld <= 1'b0;
        end else begin
            r_chk_vld <= i_cmd.rd_en;
        end
    end

    // consistency check over the fetched entries
    always_comb begin
        n_good   = r_good;
        n_seen   = r_seen;
        n_ipulse = r_ipulse;
        n_iframe = r_iframe;
        n_irec   = r_irec;
        if (i_cmd.accept && is_asm) begin
            n_good   = 1'b1;
            n_seen   = 1'b0;
            n_ipulse = '0;
            n_iframe = '0;
            n_irec   = '0;
        end else if (r_chk_vld) begin
            if (r_rd_data.packets != PKT_FULL) begin
                n_ipulse = '0;
            end else begin
                if (!r_seen) begin
                    n_ipulse = r_rd_data.pulse;
                    n_iframe = r_rd_data.frame;
                    n_irec   = r_rd_data.record;
                end
                n_seen = 1'b1;
                if ((r_rd_data.pulse != n_ipulse) || (r_rd_data.frame != n_iframe)
                    || (r_rd_data.record != n_irec)) begin
                    n_good = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_good   <= n_good;
        r_seen   <= n_seen;
        r_ipulse <= n_ipulse;
        r_iframe <= n_iframe;
        r_irec   <= n_irec;
    end

    // result register
    always_comb begin
        n_out = '0;
        if (i_cmd.emit) begin
            n_out.image_good   = r_good;
            n_out.image_pulse  = r_ipulse;
            n_out.image_frame  = r_iframe;
            n_out.image_record = r_irec;
        end else begin
            case (i_item.mode)
                MODE_CLAIM: n_out.answer_flag = claim_flag;
                MODE_QUERY: n_out.answer_flag = query_flag;
                default:    n_out.answer_flag = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_simple || i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_simple || i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_out               = r_out;
    assign o_stat.out_free     = !r_out_valid || i_out_ready;
    assign o_stat.module_count = r_module_count;

endmodule

// ===== design/detector_image_slot_assembler.sv =====
// Image slot assembler for a multi-module detector.
// Input channel i_in carries one request per transfer: mode, pulse number and
// the metadata of an arriving module frame. Output channel o_out returns exactly
// one result per request. The module count is written through i_cfg_wr_en /
// i_cfg_wr_data while no request is in flight; values above 32 are clamped.
// Claim, query, arrival, free and undefined modes: the result is valid the
// cycle after the input transfer, one request per cycle while the receiver
// keeps up.
// Assemble: the stored module entries are read one per cycle through the read
// port of the metadata memory, which has a separate write port, and
// the request channel stays not ready for that whole walk.
// One result register sits on the output; a new request is taken while the
// result is being transferred, and while the receiver stalls a held result
// blocks new requests.
// Reset (synchronous, active low) clears all slot claims and owners, sets
// every pending count and the module count to 32; the metadata memory is not
// cleared, and an entry must be written by an arrival before it is assembled.
module detector_image_slot_assembler
    import disa_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CFG_W-1:0] i_cfg_wr_data,
    disa_in_if.sink          i_in,
    disa_out_if.source       o_out
);

    t_in_item  item;
    t_out_item out_item;
    t_ctrl_cmd cmd;
    t_dp_stat  stat;
    logic      in_ready;
    logic      out_valid;

    always_comb begin
        item.mode             = i_in.mode;
        item.pulse_no         = i_in.pulse_no;
        item.module_index     = i_in.module_index;
        item.frame_pulse      = i_in.frame_pulse;
        item.frame_number     = i_in.frame_number;
        item.acq_record       = i_in.acq_record;
        item.packets_received = i_in.packets_received;
    end

    disa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_mode  (i_in.mode),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    disa_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_item        (item),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_out_valid   (out_valid),
        .i_out_ready   (o_out.ready),
        .o_out         (out_item)
    );

    assign i_in.ready         = in_ready;
    assign o_out.valid        = out_valid;
    assign o_out.answer_flag  = out_item.answer_flag;
    assign o_out.image_good   = out_item.image_good;
    assign o_out.image_pulse  = out_item.image_pulse;
    assign o_out.image_frame  = out_item.image_frame;
    assign o_out.image_record = out_item.image_record;

endmodule

// ===== design/disa_checker.sv =====
module disa_checker
    import disa_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic [MODE_W-1:0] i_in_mode,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic              i_out_good,
    input logic [PID_W-1:0]  i_out_pulse
);

    // a held result blocks new requests
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |-> !i_in_ready)
        else $error("request taken while result is stalled");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped before transfer");

    // non-assemble requests answer in the next cycle with assemble fields clear
    a_simple_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && (i_in_mode != MODE_ASM))
        |=> (i_out_valid && !i_out_good && (i_out_pulse == '0)))
        else $error("simple request result missing or malformed");

    a_asm_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && (i_in_mode == MODE_ASM)) |=> !i_in_ready)
        else $error("request taken during assemble walk");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind detector_image_slot_assembler disa_checker u_disa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_mode   (i_in.mode),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_good  (o_out.image_good),
    .i_out_pulse (o_out.image_pulse)
);

// ===== tb/tb_detector_image_slot_assembler.sv =====
module tb_detector_image_slot_assembler;
    import disa_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNDEF_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_UNDEF_HI = 3'd7;
    localparam int RANDOM_ITEMS    = 1680;
    localparam int PHASES          = 9;
    localparam int PRESSURE_AFTER  = 500;
    localparam int PRESSURE_CYCLES = 250;
    localparam int STALL_LIMIT     = 3000;

    class slot_scoreboard;
        logic [PID_W-1:0] owner [NUM_SLOTS];
        bit               claimed [NUM_SLOTS];
        int unsigned      modules_left [NUM_SLOTS];
        t_meta            meta [MEM_DEPTH];
        int unsigned      n_mod;
        t_out_item        answer_q [$];
        int               errors;
        int               requests_taken;

        function new();
            n_mod = MAX_MODULES;
            errors = 0;
            requests_taken = 0;
            for (int s = 0; s < NUM_SLOTS; s++) begin
                owner[s] = '0;
                claimed[s] = 0;
                modules_left[s] = n_mod;
            end
            for (int a = 0; a < MEM_DEPTH; a++) begin
                meta[a] = '0;
            end
        endfunction

        function void set_modules(logic [CFG_W-1:0] v);
            n_mod = (v > MAX_MODULES) ? MAX_MODULES : v;
        endfunction

        function t_out_item predict_answer(t_in_item req);
            t_out_item   a;
            int unsigned s;
            bit          seen;
            t_meta       e;
            a = '0;
            s = req.pulse_no[SLOT_W-1:0];
            case (req.mode)
                MODE_CLAIM: begin
                    if (!claimed[s]) begin
                        claimed[s] = 1;
                        owner[s] = req.pulse_no;
                        a.answer_flag = 1'b1;
                    end else begin
                        a.answer_flag = (modules_left[s] > 0) && (owner[s] == req.pulse_no);
                    end
                end
                MODE_QUERY: a.answer_flag = (modules_left[s] == 0);
                MODE_ARRIVE: begin
                    if (req.module_index < n_mod) begin
                        meta[s * MAX_MODULES + req.module_index] = {req.frame_pulse,
                            req.frame_number, req.acq_record, req.packets_received};
                        if (modules_left[s] > 0) modules_left[s]--;
                    end
                end
                MODE_FREE: begin
                    modules_left[s] = n_mod;
                    claimed[s] = 0;
                    owner[s] = '0;
                end
                MODE_ASM: begin
                    a.image_good = 1'b1;
                    seen = 0;
                    for (int unsigned i = 0; i < n_mod; i++) begin
                        e = meta[s * MAX_MODULES + i];
                        if (e.packets != PKT_FULL) begin
                            a.image_pulse = '0;
                        end else begin
                            if (!seen) begin
                                a.image_pulse = e.pulse;
                                a.image_frame = e.frame;
                                a.image_record = e.record;
                                seen = 1;
                            end
                            if (e.pulse != a.image_pulse || e.frame != a.image_frame ||
                                e.record != a.image_record) a.image_good = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
            return a;
        endfunction

        function void note_request(t_in_item req);
            requests_taken++;
            answer_q.push_back(predict_answer(req));
        endfunction

        function void mismatch(string field, logic [PID_W-1:0] want, logic [PID_W-1:0] got);
            errors++;
            $display("%0t: %s expected %h got %h", $time, field, want, got);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (answer_q.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected, got %h", $time, got);
                return;
            end
            want = answer_q.pop_front();
            if (got.answer_flag !== want.answer_flag)
                mismatch("answer_flag", want.answer_flag, got.answer_flag);
            if (got.image_good !== want.image_good)
                mismatch("image_good", want.image_good, got.image_good);
            if (got.image_pulse !== want.image_pulse)
                mismatch("image_pulse", want.image_pulse, got.image_pulse);
            if (got.image_frame !== want.image_frame)
                mismatch("image_frame", want.image_frame, got.image_frame);
            if (got.image_record !== want.image_record)
                mismatch("image_record", want.image_record, got.image_record);
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic [CFG_W-1:0] i_cfg_wr_data;

    disa_in_if  in_if ();
    disa_out_if out_if ();

    detector_image_slot_assembler uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (in_if),
        .o_out         (out_if)
    );

    slot_scoreboard   sb = new();
    // which metadata entries have been written, tracked as requests are issued
    logic [MAX_MODULES-1:0] meta_written [NUM_SLOTS];
    int               stim_count;
    bit               sender_calm;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [PID_W-1:0] random64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_in_item make_req(logic [MODE_W-1:0] mode, logic [PID_W-1:0] pid,
                                          logic [MOD_W-1:0] idx, logic [PID_W-1:0] fp,
                                          logic [PID_W-1:0] fn, logic [REC_W-1:0] rec,
                                          logic [PKT_W-1:0] pk);
        t_in_item req;
        req.mode = mode;
        req.pulse_no = pid;
        req.module_index = idx;
        req.frame_pulse = fp;
        req.frame_number = fn;
        req.acq_record = rec;
        req.packets_received = pk;
        return req;
    endfunction

    function automatic t_in_item random_request();
        return make_req(MODE_W'($urandom_range(0, 7)), random64(),
                        MOD_W'($urandom_range(0, MAX_MODULES - 1)),
                        random64(), random64(), $urandom, PKT_W'($urandom_range(0, 255)));
    endfunction

    task automatic sender_gap();
        int r;
        int gap;
        r = $urandom_range(0, 99);
        gap = 0;
        if (!sender_calm) begin
            if (r >= 90) gap = $urandom_range(10, 40);
            else if (r >= 55) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic issue(input t_in_item req);
        logic [SLOT_W-1:0] s;
        bit                all_written;
        s = req.pulse_no[SLOT_W-1:0];
        if (req.mode == MODE_ASM) begin
            all_written = 1;
            for (int i = 0; i < sb.n_mod; i++) begin
                if (!meta_written[s][i]) all_written = 0;
            end
            // never let assemble read an entry that no arrival has written
            if (!all_written) req.mode = MODE_QUERY;
        end
        if (req.mode == MODE_ARRIVE && req.module_index < sb.n_mod)
            meta_written[s][req.module_index] = 1'b1;
        if (req.mode <= MODE_ASM && !(req.mode == MODE_ARRIVE && req.module_index >= sb.n_mod))
            stim_count++;
        sender_gap();
        in_if.mode             <= req.mode;
        in_if.pulse_no         <= req.pulse_no;
        in_if.module_index     <= req.module_index;
        in_if.frame_pulse      <= req.frame_pulse;
        in_if.frame_number     <= req.frame_number;
        in_if.acq_record       <= req.acq_record;
        in_if.packets_received <= req.packets_received;
        in_if.valid            <= 1'b1;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_request(req);
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.answer_q.size() != 0) @(posedge i_clk);
        repeat (MAX_MODULES + 8) @(posedge i_clk);
    endtask

    task automatic write_modules(input logic [CFG_W-1:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.set_modules(v);
    endtask

    task automatic image_sequence();
        t_in_item         req;
        logic [PID_W-1:0] pid;
        t_meta            base;
        int               order [MAX_MODULES];
        int               n;
        int               j;
        int               tmp;
        int               r;
        n = sb.n_mod;
        sender_calm = ($urandom_range(0, 4) == 0);
        pid = random64();
        base.pulse = ($urandom_range(0, 3) == 0) ? random64() : pid;
        base.frame = random64();
        base.record = $urandom;
        req = random_request();
        req.mode = MODE_CLAIM;
        req.pulse_no = pid;
        issue(req);
        if ($urandom_range(0, 9) == 0) begin
            // a rival pulse mapping to the same slot
            req.pulse_no = pid ^ (random64() << SLOT_W);
            issue(req);
        end
        for (int k = 0; k < n; k++) order[k] = k;
        for (int k = n - 1; k > 0; k--) begin
            j = $urandom_range(0, k);
            tmp = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 19) != 0) begin
                req = make_req(MODE_ARRIVE, pid, MOD_W'(order[k]), base.pulse, base.frame,
                               base.record,
                               ($urandom_range(0, 9) == 0) ? PKT_W'($urandom_range(0, 255))
                                                            : PKT_FULL);
                r = $urandom_range(0, 29);
                if (r == 0) req.frame_pulse ^= 64'd1 << $urandom_range(0, 63);
                if (r == 1) req.frame_number ^= 64'd1 << $urandom_range(0, 63);
                if (r == 2) req.acq_record ^= 32'd1 << $urandom_range(0, 31);
                issue(req);
                if ($urandom_range(0, 7) == 0) begin
                    req.mode = MODE_QUERY;
                    issue(req);
                end
            end
        end
        req = random_request();
        req.pulse_no = pid;
        req.mode = MODE_QUERY;
        issue(req);
        req.mode = MODE_ASM;
        issue(req);
        if ($urandom_range(0, 4) != 0) begin
            req.mode = MODE_FREE;
            issue(req);
        end
    endtask

    task automatic directed_checks();
        logic [PID_W-1:0] p;
        logic [PID_W-1:0] q;
        p = '1;
        q = 64'h0123_4567_89ab_cdef;
        write_modules(6'd3);
        issue(make_req(MODE_CLAIM, p, '0, '0, '0, '0, '0));
        issue(make_req(MODE_CLAIM, p, '0, '0, '0, '0, '0));
        issue(make_req(MODE_CLAIM, q, '0, '0, '0, '0, '0));
        issue(make_req(MODE_QUERY, p, '0, '0, '0, '0, '0));
        issue(make_req(MODE_ARRIVE, p, MOD_W'(0), '1, '1, '1, PKT_FULL));
        issue(make_req(MODE_ARRIVE, p, MOD_W'(1), '1, '1, '1, 8'hFF));
        issue(make_req(MODE_ARRIVE, p, MOD_W'(2), '1, '1, '1, PKT_FULL));
        // module index beyond the module count is dropped
        issue(make_req(MODE_ARRIVE, p, MOD_W'(MAX_MODULES - 1), '0, '0, '0, PKT_FULL));
        issue(make_req(MODE_QUERY, p, '0, '0, '0, '0, '0));
        issue(make_req(MODE_CLAIM, p, '0, '0, '0, '0, '0));
        issue(make_req(MODE_ASM, p, '0, '0, '0, '0, '0));
        // pending count already at zero, must stay there
        issue(make_req(MODE_ARRIVE, p, MOD_W'(1), '1, '1, '1, PKT_FULL));
        issue(make_req(MODE_ASM, p, '0, '0, '0, '0, '0));
        issue(make_req(MODE_ARRIVE, p, MOD_W'(2), '1, '0, '1, PKT_FULL));
        issue(make_req(MODE_ASM, p, '0, '0, '0, '0, '0));
        issue(make_req(MODE_FREE, p, '0, '0, '0, '0, '0));
        issue(make_req(MODE_QUERY, p, '0, '0, '0, '0, '0));
        issue(make_req(MODE_CLAIM, q, '0, '0, '0, '0, '0));
        // slot with no complete frame at all
        for (int m = 0; m < 3; m++)
            issue(make_req(MODE_ARRIVE, '0, MOD_W'(m), '0, '0, '0, '0));
        issue(make_req(MODE_ASM, '0, '0, '0, '0, '0, '0));
        issue(make_req(MODE_UNDEF_LO, random64(), MOD_W'(5), random64(), random64(), $urandom,
                       8'hA5));
        issue(make_req(MODE_UNDEF_HI, '1, '1, '1, '1, '1, '1));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_result({out_if.answer_flag, out_if.image_good, out_if.image_pulse,
                             out_if.image_frame, out_if.image_record});
    end

    initial begin : result_sink
        int  run;
        int  hold;
        int  r;
        bit  pressed;
        pressed = 0;
        out_if.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (!pressed && sb.requests_taken >= PRESSURE_AFTER) begin
                // long hold-off so results back up into the input side
                pressed = 1;
                out_if.ready <= 1'b0;
                repeat (PRESSURE_CYCLES) @(posedge i_clk);
            end
            r = $urandom_range(0, 99);
            run = (r < 10) ? $urandom_range(50, 150) : $urandom_range(1, 12);
            out_if.ready <= 1'b1;
            repeat (run) @(posedge i_clk);
            r = $urandom_range(0, 99);
            hold = (r < 50) ? 0 : (r < 88) ? $urandom_range(1, 3) : $urandom_range(5, 30);
            if (hold > 0) begin
                out_if.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
            else quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        logic [CFG_W-1:0] setting;
        logic [CFG_W-1:0] phase_setting [PHASES];
        int               target;
        phase_setting = '{6'd32, 6'd1, 6'd0, 6'd63, 6'd5, 6'd0, 6'd16, 6'd40, 6'd32};
        stim_count = 0;
        sender_calm = 0;
        for (int s = 0; s < NUM_SLOTS; s++) meta_written[s] = '0;
        i_rst_n                = 1'b0;
        i_cfg_wr_en            = 1'b0;
        i_cfg_wr_data          = '0;
        in_if.valid            = 1'b0;
        in_if.mode             = MODE_CLAIM;
        in_if.pulse_no         = '0;
        in_if.module_index     = '0;
        in_if.frame_pulse      = '0;
        in_if.frame_number     = '0;
        in_if.acq_record       = '0;
        in_if.packets_received = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed_checks();
        for (int p = 0; p < PHASES; p++) begin
            drain();
            setting = (p == 5) ? CFG_W'($urandom_range(2, 31)) : phase_setting[p];
            write_modules(setting);
            target = stim_count + RANDOM_ITEMS / PHASES;
            while (stim_count < target) begin
                if ($urandom_range(0, 3) != 0) begin
                    image_sequence();
                end else begin
                    sender_calm = 0;
                    issue(random_request());
                end
            end
        end
        drain();
        if (sb.errors == 0 && sb.answer_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/disa_pkg.sv
design/disa_in_if.sv
design/disa_out_if.sv
design/disa_ctrl.sv
design/disa_dp.sv
design/detector_image_slot_assembler.sv
design/disa_checker.sv
tb/tb_detector_image_slot_assembler.sv
